/* rtl/kstm_pkg.sv */
// ----------------------------------------------------------------------------
// kstm_pkg
// Shared types and constants for the spanning-forest merge unit.
// ----------------------------------------------------------------------------
package kstm_pkg;

    // Field widths of the edge and result items.
    localparam int NODE_W = 6;
    localparam int COST_W = 24;
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 6;

    // Saturation points.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    // Classification of an incoming item.
    typedef enum logic [1:0] {
        K_EDGE,
        K_CLEAR,
        K_NULL
    } t_kind;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WR_B,
        S_SWEEP,
        S_FLUSH
    } t_state;

    // One classified command.
    typedef struct packed {
        t_kind             kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [COST_W-1:0] cost;
    } t_op;

    // Front to queue push.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic avail;
        t_op  op;
    } t_q_head;

    // One result item.
    typedef struct packed {
        logic              accepted;
        logic [SUM_W-1:0]  total_cost;
        logic              cost_saturated;
        logic [CNT_W-1:0]  tree_edges;
        logic [NODE_W-1:0] root_node;
    } t_result;

endpackage

/* rtl/kstm_ifs.sv */
// ----------------------------------------------------------------------------
// kstm interfaces
// Valid/ready channels for edge items and result items.
// ----------------------------------------------------------------------------
interface kstm_edge_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [kstm_pkg::NODE_W-1:0]    node_a;
    logic [kstm_pkg::NODE_W-1:0]    node_b;
    logic [kstm_pkg::COST_W-1:0]    edge_cost;

    modport source (output valid, mode, node_a, node_b, edge_cost, input ready);
    modport sink   (input valid, mode, node_a, node_b, edge_cost, output ready);
endinterface

interface kstm_result_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [kstm_pkg::SUM_W-1:0]     total_cost;
    logic                           cost_saturated;
    logic [kstm_pkg::CNT_W-1:0]     tree_edges;
    logic [kstm_pkg::NODE_W-1:0]    root_node;

    modport source (output valid, accepted, total_cost, cost_saturated, tree_edges,
                    root_node, input ready);
    modport sink   (input valid, accepted, total_cost, cost_saturated, tree_edges,
                    root_node, output ready);
endinterface

/* rtl/kstm_front.sv */
// ----------------------------------------------------------------------------
// kstm_front
// Accepts edge items and classifies them as clear, null or real edge.
// ----------------------------------------------------------------------------
module kstm_front #(
    parameter int MAX_NODES = 63
) (
    kstm_edge_if.sink          i_edge,
    input  logic               i_q_ready,
    output kstm_pkg::t_push    o_push
);

    localparam int LW = $clog2(MAX_NODES + 1);
    localparam int CW = (LW > kstm_pkg::NODE_W) ? LW : kstm_pkg::NODE_W;

    logic          a_ok;
    logic          b_ok;
    kstm_pkg::t_op op;

    // An endpoint is usable when it is nonzero and inside the node range.
    assign a_ok = (i_edge.node_a != '0) &&
                  (CW'(i_edge.node_a) <= CW'(MAX_NODES));
    assign b_ok = (i_edge.node_b != '0) &&
                  (CW'(i_edge.node_b) <= CW'(MAX_NODES));

    // Classify the item; self loops never touch the forest.
    always_comb begin
        op.node_a = i_edge.node_a;
        op.node_b = i_edge.node_b;
        op.cost   = i_edge.edge_cost;
        if (i_edge.mode) begin
            op.kind = kstm_pkg::K_CLEAR;
        end else if (a_ok && b_ok && (i_edge.node_a != i_edge.node_b)) begin
            op.kind = kstm_pkg::K_EDGE;
        end else begin
            op.kind = kstm_pkg::K_NULL;
        end
    end

    // The front stalls only when the queue is full.
    assign i_edge.ready = i_q_ready;
    assign o_push.valid = i_edge.valid && i_q_ready;
    assign o_push.op    = op;

endmodule

/* rtl/kstm_queue.sv */
// ----------------------------------------------------------------------------
// kstm_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module kstm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kstm_pkg::t_push     i_push,
    output logic                o_ready,
    input  logic                i_pop,
    output kstm_pkg::t_q_head   o_head
);

    kstm_pkg::t_op                  r_slot [kstm_pkg::Q_DEPTH];
    logic [kstm_pkg::QA_W-1:0]      r_wr_ptr;
    logic [kstm_pkg::QA_W-1:0]      r_rd_ptr;
    logic [kstm_pkg::QA_W:0]        r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_ready     = (r_count != (kstm_pkg::QA_W + 1)'(kstm_pkg::Q_DEPTH));
    assign o_head.avail = (r_count != '0);
    assign o_head.op    = r_slot[r_rd_ptr];
    assign do_push      = i_push.valid && o_ready;
    assign do_pop       = i_pop && o_head.avail;

    // Pointer and count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == kstm_pkg::QA_W'(kstm_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == kstm_pkg::QA_W'(kstm_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Payload slots.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.op;
        end
    end

endmodule

/* rtl/kstm_back.sv */
// ----------------------------------------------------------------------------
// kstm_back
// Executes queued commands against the label memory and keeps the totals.
// ----------------------------------------------------------------------------
module kstm_back #(
    parameter int MAX_NODES = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kstm_pkg::t_q_head   i_head,
    output logic                o_pop,
    kstm_result_if.source       o_result
);

    localparam int LW = $clog2(MAX_NODES + 1);
    localparam int NW = kstm_pkg::NODE_W;

    // Label memory and its per-entry valid bits.
    logic [NW-1:0]                  mem [0:MAX_NODES];
    logic [MAX_NODES:0]             r_valid;
    logic [NW-1:0]                  r_rd_a;
    logic [NW-1:0]                  r_rd_b;
    logic                           r_va;
    logic                           r_vb;

    // Sequencer and totals.
    kstm_pkg::t_state               r_state, n_state;
    kstm_pkg::t_op                  r_op, n_op;
    logic [NW-1:0]                  r_la, n_la;
    logic [NW-1:0]                  r_lb, n_lb;
    logic [NW-1:0]                  r_new, n_new;
    logic [LW-1:0]                  r_j, n_j;
    logic                           r_cmp_vld, n_cmp_vld;
    logic [LW-1:0]                  r_cmp_addr, n_cmp_addr;
    logic [kstm_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic                           r_sat, n_sat;
    logic [kstm_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [NW-1:0]                  r_root, n_root;
    logic                           r_out_valid, n_out_valid;
    kstm_pkg::t_result              r_out, n_out;

    // Memory port controls.
    logic                           rd_en;
    logic [LW-1:0]                  rd_addr_a;
    logic [LW-1:0]                  rd_addr_b;
    logic                           wr_en;
    logic [LW-1:0]                  wr_addr;
    logic [NW-1:0]                  wr_data;
    logic                           clr_all;

    logic                           slot_free;
    logic [NW-1:0]                  la;
    logic [NW-1:0]                  lb;
    logic [kstm_pkg::SUM_W:0]       sum_ext;

    assign slot_free = !r_out_valid || o_result.ready;
    assign la        = r_va ? r_rd_a : '0;
    assign lb        = r_vb ? r_rd_b : '0;
    assign sum_ext   = {1'b0, r_sum} + (kstm_pkg::SUM_W + 1)'(r_op.cost);

    // Next state, memory controls and result loading.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_la        = r_la;
        n_lb        = r_lb;
        n_new       = r_new;
        n_j         = r_j;
        n_cmp_vld   = 1'b0;
        n_cmp_addr  = r_cmp_addr;
        n_sum       = r_sum;
        n_sat       = r_sat;
        n_cnt       = r_cnt;
        n_root      = r_root;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr_a   = LW'(i_head.op.node_a);
        rd_addr_b   = LW'(i_head.op.node_b);
        wr_en       = 1'b0;
        wr_addr     = LW'(r_op.node_a);
        wr_data     = r_new;
        clr_all     = 1'b0;

        case (r_state)
            kstm_pkg::S_IDLE: begin
                if (i_head.avail) begin
                    case (i_head.op.kind)
                        kstm_pkg::K_CLEAR: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                clr_all     = 1'b1;
                                n_sum       = '0;
                                n_sat       = 1'b0;
                                n_cnt       = '0;
                                n_root      = '0;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                            end
                        end
                        kstm_pkg::K_NULL: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = {1'b0, r_sum, r_sat, r_cnt, r_root};
                            end
                        end
                        default: begin
                            // Real edge: fetch both endpoint labels.
                            o_pop   = 1'b1;
                            rd_en   = 1'b1;
                            n_op    = i_head.op;
                            n_state = kstm_pkg::S_LOOK;
                        end
                    endcase
                end
            end
            kstm_pkg::S_LOOK: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if ((la != '0) && (la == lb)) begin
                        // Both ends already in one tree: this edge closes a cycle.
                        n_out   = {1'b0, r_sum, r_sat, r_cnt, r_root};
                        n_state = kstm_pkg::S_IDLE;
                    end else begin
                        if (sum_ext[kstm_pkg::SUM_W]) begin
                            n_sum = kstm_pkg::SUM_MAX;
                            n_sat = 1'b1;
                        end else begin
                            n_sum = sum_ext[kstm_pkg::SUM_W-1:0];
                        end
                        if (r_cnt != kstm_pkg::CNT_MAX) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        if (r_root == '0) begin
                            n_root = r_op.node_a;
                        end
                        n_out = {1'b1, n_sum, n_sat, n_cnt, n_root};
                        if ((la == '0) && (lb == '0)) begin
                            wr_en   = 1'b1;
                            wr_data = r_op.node_a;
                            n_new   = r_op.node_a;
                            n_state = kstm_pkg::S_WR_B;
                        end else if ((la == '0) || (lb == '0)) begin
                            wr_en   = 1'b1;
                            wr_data = (la != '0) ? la : lb;
                            n_new   = (la != '0) ? la : lb;
                            n_state = kstm_pkg::S_WR_B;
                        end else begin
                            // Two labeled trees: relabel every node of the first.
                            n_la    = la;
                            n_lb    = lb;
                            n_j     = LW'(1);
                            n_state = kstm_pkg::S_SWEEP;
                        end
                    end
                end
            end
            kstm_pkg::S_WR_B: begin
                wr_en   = 1'b1;
                wr_addr = LW'(r_op.node_b);
                wr_data = r_new;
                n_state = kstm_pkg::S_IDLE;
            end
            kstm_pkg::S_SWEEP: begin
                rd_en      = 1'b1;
                rd_addr_a  = r_j;
                n_cmp_vld  = 1'b1;
                n_cmp_addr = r_j;
                if (r_j == LW'(MAX_NODES)) begin
                    n_state = kstm_pkg::S_FLUSH;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            kstm_pkg::S_FLUSH: begin
                n_state = kstm_pkg::S_IDLE;
            end
            default: begin
                n_state = kstm_pkg::S_IDLE;
            end
        endcase

        // Sweep write-back: one entry behind the read.
        if (r_cmp_vld && r_va && (r_rd_a == r_la)) begin
            wr_en   = 1'b1;
            wr_addr = r_cmp_addr;
            wr_data = r_lb;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kstm_pkg::S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_cnt       <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_sum       <= n_sum;
            r_sat       <= n_sat;
            r_cnt       <= n_cnt;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_la       <= n_la;
        r_lb       <= n_lb;
        r_new      <= n_new;
        r_j        <= n_j;
        r_cmp_addr <= n_cmp_addr;
        r_out      <= n_out;
    end

    // Valid bits: a clear empties the whole forest at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
        if (rd_en) begin
            r_va <= r_valid[rd_addr_a];
            r_vb <= r_valid[rd_addr_b];
        end
    end

    // Label memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.accepted       = r_out.accepted;
    assign o_result.total_cost     = r_out.total_cost;
    assign o_result.cost_saturated = r_out.cost_saturated;
    assign o_result.tree_edges     = r_out.tree_edges;
    assign o_result.root_node      = r_out.root_node;

endmodule

/* rtl/kruskal_spanning_tree_merge.sv */
// ----------------------------------------------------------------------------
// kruskal_spanning_tree_merge
// Spanning-forest builder: merges components for edges offered in cost order.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_edge     in   valid/ready    mode, node_a, node_b, edge_cost
//  o_result   out  valid/ready    accepted, total_cost, cost_saturated,
//                                 tree_edges, root_node
//
// A clear or a null edge is handled in S_IDLE; a rejected edge also visits S_LOOK.
// An edge that touches an unlabeled node goes through S_LOOK and S_WR_B.
// Joining two labeled trees goes through S_LOOK, S_SWEEP and S_FLUSH: the label
// memory is swept one entry per cycle through its single write port.
// Reset is synchronous; a clear empties the whole forest at once.
// The output register lets the front keep queueing edges while a result waits.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree_merge #(
    parameter int MAX_NODES = 63
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kstm_edge_if.sink       i_edge,
    kstm_result_if.source   o_result
);

    kstm_pkg::t_push    push;
    kstm_pkg::t_q_head  head;
    logic               q_ready;
    logic               pop;

    // Classifier.
    kstm_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_edge    (i_edge),
        .i_q_ready (q_ready),
        .o_push    (push)
    );

    // Command queue.
    kstm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_head  (head)
    );

    // Executor with label memory and totals.
    kstm_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

/* rtl/kstm_checker.sv */
// ----------------------------------------------------------------------------
// kstm_checker
// Port-level checks on the result stream of the spanning-forest builder.
// ----------------------------------------------------------------------------
module kstm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_accepted,
    input logic [kstm_pkg::SUM_W-1:0]   i_total_cost,
    input logic                         i_cost_saturated,
    input logic [kstm_pkg::CNT_W-1:0]   i_tree_edges,
    input logic [kstm_pkg::NODE_W-1:0]  i_root_node
);

    // A stalled result stays valid and holds its total, edge count and accepted flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_total_cost) &&
                                $stable(i_tree_edges) && $stable(i_accepted))
        else $error("result changed while stalled");

    // An accepted edge means the forest has a root and a nonzero edge count.
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_accepted |-> (i_tree_edges != '0) && (i_root_node != '0))
        else $error("accepted edge without root or count");

    // A saturated total is pinned at its maximum.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_cost_saturated |-> (i_total_cost == kstm_pkg::SUM_MAX))
        else $error("saturated flag with unclamped total");

    // An empty forest has no cost and no root.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_tree_edges == '0) |->
            (i_total_cost == '0) && (i_root_node == '0) && !i_cost_saturated)
        else $error("empty forest with nonzero totals");

    // Nothing is presented right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind kruskal_spanning_tree_merge kstm_checker u_kstm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_result.valid),
    .i_ready          (o_result.ready),
    .i_accepted       (o_result.accepted),
    .i_total_cost     (o_result.total_cost),
    .i_cost_saturated (o_result.cost_saturated),
    .i_tree_edges     (o_result.tree_edges),
    .i_root_node      (o_result.root_node)
);
